// ----- rtl/triangle_surface_point_sampler_defines.svh -----
// Assertion macros for the triangle surface point sampler.
`ifndef TRIANGLE_SURFACE_POINT_SAMPLER_DEFINES_SVH
`define TRIANGLE_SURFACE_POINT_SAMPLER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TSPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tsps assertion failed");

// Next-cycle implication, disabled during reset.
`define TSPS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tsps assertion failed");

`endif

// ----- rtl/tsps_pkg.sv -----
// Types and constants for the triangle surface point sampler.
package tsps_pkg;

    localparam int COORD_W = 32;
    localparam int EDGE_W  = 33;
    localparam int DRAW_W  = 16;
    localparam int NRM_W   = 16;
    localparam int MANT_W  = 30;
    localparam int DIV_W   = 47;

    localparam logic [16:0] Q16_ONE = 17'd65536;
    localparam logic signed [NRM_W-1:0] Q14_ONE = 16'sd16384;

    // Pipeline stage numbers
    localparam int ST_EDGE  = 1;
    localparam int ST_PART  = 2;
    localparam int ST_PROD  = 3;
    localparam int ST_CROSS = 4;
    localparam int ST_MAG   = 5;
    localparam int ST_LEN   = 6;
    localparam int ST_MANT  = 7;
    localparam int ST_SQR   = 8;
    localparam int ST_SUM   = 9;
    localparam int ST_NSQ_END = 25;
    localparam int ST_NUM   = 26;
    localparam int ST_DV_END = 34;
    localparam int ST_PSQ_END = 9;
    localparam int ST_WGT   = 10;
    localparam int ST_TERM  = 11;
    localparam int ST_PT    = 12;
    localparam int ST_OUT   = 35;

    typedef struct packed {
        logic [63:0] rad;
        logic [34:0] rem;
        logic [31:0] root;
    } t_sq;

    typedef struct packed {
        logic [DIV_W-1:0] rem;
        logic [15:0]      q;
    } t_div;

    typedef struct packed {
        logic       want;
        logic       zero;
        logic [2:0] neg;
    } t_nctl;

endpackage

// ----- rtl/triangle_surface_point_sampler.sv -----
// Triangle surface point sampler: uniform point and optional unit face normal.
// Throughput: one beat per cycle unless a finished beat is stalled; the
// normal path (cross product, 32-bit square root at two bits per stage,
// 16-bit division at two bits per stage) sets the depth. The whole pipeline
// holds while a finished beat is stalled.
// Reset (synchronous, active low) clears all valid bits; payload is not reset.
`include "triangle_surface_point_sampler_defines.svh"

module triangle_surface_point_sampler (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic signed [tsps_pkg::COORD_W-1:0]    i_ax,
    input  logic signed [tsps_pkg::COORD_W-1:0]    i_ay,
    input  logic signed [tsps_pkg::COORD_W-1:0]    i_az,
    input  logic signed [tsps_pkg::COORD_W-1:0]    i_bx,
    input  logic signed [tsps_pkg::COORD_W-1:0]    i_by,
    input  logic signed [tsps_pkg::COORD_W-1:0]    i_bz,
    input  logic signed [tsps_pkg::COORD_W-1:0]    i_cx,
    input  logic signed [tsps_pkg::COORD_W-1:0]    i_cy,
    input  logic signed [tsps_pkg::COORD_W-1:0]    i_cz,
    input  logic        [tsps_pkg::DRAW_W-1:0]     i_r_radial,
    input  logic        [tsps_pkg::DRAW_W-1:0]     i_r_mix,
    input  logic                                   i_want_normal,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic signed [tsps_pkg::COORD_W-1:0]    o_px,
    output logic signed [tsps_pkg::COORD_W-1:0]    o_py,
    output logic signed [tsps_pkg::COORD_W-1:0]    o_pz,
    output logic signed [tsps_pkg::NRM_W-1:0]      o_nx,
    output logic signed [tsps_pkg::NRM_W-1:0]      o_ny,
    output logic signed [tsps_pkg::NRM_W-1:0]      o_nz
);

    // One square-root digit: bring down two radicand bits, try root*4+1.
    function automatic tsps_pkg::t_sq sq_step(tsps_pkg::t_sq x);
        tsps_pkg::t_sq y;
        logic [34:0]   cur;
        logic [34:0]   trial;
        cur   = {x.rem[32:0], x.rad[63:62]};
        trial = {1'b0, x.root, 2'b01};
        y.rad = {x.rad[61:0], 2'b00};
        if (cur >= trial) begin
            y.rem  = cur - trial;
            y.root = {x.root[30:0], 1'b1};
        end else begin
            y.rem  = cur;
            y.root = {x.root[30:0], 1'b0};
        end
        return y;
    endfunction

    // Two restoring-division quotient bits at positions sh and sh-1.
    function automatic tsps_pkg::t_div div_step2(tsps_pkg::t_div x, logic [31:0] d, int sh);
        tsps_pkg::t_div y;
        logic [tsps_pkg::DIV_W-1:0] dh;
        logic [tsps_pkg::DIV_W-1:0] dl;
        y  = x;
        dh = tsps_pkg::DIV_W'(d) << sh;
        dl = tsps_pkg::DIV_W'(d) << (sh - 1);
        if (y.rem >= dh) begin
            y.rem   = y.rem - dh;
            y.q[sh] = 1'b1;
        end
        if (y.rem >= dl) begin
            y.rem       = y.rem - dl;
            y.q[sh - 1] = 1'b1;
        end
        return y;
    endfunction

    // Advance the whole pipeline unless a finished beat waits at the output.
    logic w_adv;
    logic [tsps_pkg::ST_OUT:1] r_vld;

    assign w_adv   = !(r_vld[tsps_pkg::ST_OUT] && i_stall);
    assign o_stall = !w_adv;
    assign o_valid = r_vld[tsps_pkg::ST_OUT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[tsps_pkg::ST_OUT-1:1], i_valid};
        end
    end

    // ------------------------------------------------------------------
    // Point path: sqrt of the radial draw, weights, nine products, sum.
    // ------------------------------------------------------------------
    logic signed [31:0] r_vtx [tsps_pkg::ST_EDGE:tsps_pkg::ST_WGT][9];
    logic [15:0]        r_mix [tsps_pkg::ST_EDGE:tsps_pkg::ST_PSQ_END];
    tsps_pkg::t_sq      r_psq [tsps_pkg::ST_EDGE:tsps_pkg::ST_PSQ_END];
    logic [16:0]        r_wa, r_wb, r_wc;
    logic signed [33:0] r_term [3][3];
    logic signed [31:0] r_pt [tsps_pkg::ST_PT:tsps_pkg::ST_OUT][3];

    logic [15:0]        w_s;
    logic [32:0]        w_pb, w_pc;
    logic signed [49:0] w_pr [3][3];
    logic [16:0]        w_wgt [3];

    assign w_s  = r_psq[tsps_pkg::ST_PSQ_END].root[15:0];
    assign w_pb = 33'(w_s) * 33'(tsps_pkg::Q16_ONE - {1'b0, r_mix[tsps_pkg::ST_PSQ_END]});
    assign w_pc = 33'(w_s) * 33'(r_mix[tsps_pkg::ST_PSQ_END]);

    always_comb begin
        w_wgt[0] = r_wa;
        w_wgt[1] = r_wb;
        w_wgt[2] = r_wc;
        for (int v = 0; v < 3; v++) begin
            for (int i = 0; i < 3; i++) begin
                w_pr[v][i] = 50'($signed({1'b0, w_wgt[v]})) * 50'(r_vtx[tsps_pkg::ST_WGT][3*v+i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_vtx[tsps_pkg::ST_EDGE] <= '{i_ax, i_ay, i_az, i_bx, i_by, i_bz, i_cx, i_cy, i_cz};
            r_mix[tsps_pkg::ST_EDGE] <= i_r_mix;
            r_psq[tsps_pkg::ST_EDGE] <= '{rad: {i_r_radial, 48'd0}, rem: '0, root: '0};
            for (int k = tsps_pkg::ST_EDGE + 1; k <= tsps_pkg::ST_WGT; k++) begin
                r_vtx[k] <= r_vtx[k-1];
            end
            for (int k = tsps_pkg::ST_EDGE + 1; k <= tsps_pkg::ST_PSQ_END; k++) begin
                r_mix[k] <= r_mix[k-1];
                r_psq[k] <= sq_step(sq_step(r_psq[k-1]));
            end
            // weights: wa = 1 - s, wb = s*(1-r_mix), wc = s*r_mix
            r_wa <= tsps_pkg::Q16_ONE - {1'b0, w_s};
            r_wb <= w_pb[32:16];
            r_wc <= w_pc[32:16];
            // floor each product to Q16.16 by arithmetic shift
            for (int v = 0; v < 3; v++) begin
                for (int i = 0; i < 3; i++) begin
                    r_term[v][i] <= w_pr[v][i][49:16];
                end
            end
            for (int i = 0; i < 3; i++) begin
                r_pt[tsps_pkg::ST_PT][i] <= 32'(r_term[0][i] + r_term[1][i] + r_term[2][i]);
            end
            for (int k = tsps_pkg::ST_PT + 1; k <= tsps_pkg::ST_OUT; k++) begin
                r_pt[k] <= r_pt[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Normal path: edges, split cross products, normalize to 30 bits,
    // norm by square root, divide each component by the norm.
    // ------------------------------------------------------------------
    logic signed [32:0] r_e1 [3];
    logic signed [32:0] r_e2 [3];
    logic signed [50:0] r_pl [6];
    logic signed [48:0] r_ph [6];
    logic signed [65:0] r_prod [6];
    logic signed [66:0] r_cross [3];
    logic [65:0]        r_mag [tsps_pkg::ST_MAG:tsps_pkg::ST_LEN][3];
    logic [6:0]         r_len;
    logic [29:0]        r_m [tsps_pkg::ST_MANT:tsps_pkg::ST_NUM][3];
    logic [59:0]        r_sqr [3];
    tsps_pkg::t_sq      r_nsq [tsps_pkg::ST_SUM:tsps_pkg::ST_NSQ_END];
    tsps_pkg::t_div     r_dv [tsps_pkg::ST_NUM:tsps_pkg::ST_DV_END][3];
    logic [31:0]        r_dvd [tsps_pkg::ST_NUM:tsps_pkg::ST_DV_END];
    tsps_pkg::t_nctl    r_nc [tsps_pkg::ST_EDGE:tsps_pkg::ST_OUT];
    tsps_pkg::t_nctl    n_nc [tsps_pkg::ST_EDGE:tsps_pkg::ST_OUT];
    logic signed [15:0] r_nrm [3];

    logic signed [32:0] w_mx [6];
    logic signed [32:0] w_my [6];
    logic [65:0]        w_or;
    logic [6:0]         w_len;
    logic [29:0]        w_m [3];
    logic [31:0]        w_norm;

    // Operand pairs: c0 = e1y*e2z - e1z*e2y, c1 = e1z*e2x - e1x*e2z,
    // c2 = e1x*e2y - e1y*e2x.
    always_comb begin
        w_mx[0] = r_e1[1]; w_my[0] = r_e2[2];
        w_mx[1] = r_e1[2]; w_my[1] = r_e2[1];
        w_mx[2] = r_e1[2]; w_my[2] = r_e2[0];
        w_mx[3] = r_e1[0]; w_my[3] = r_e2[2];
        w_mx[4] = r_e1[0]; w_my[4] = r_e2[1];
        w_mx[5] = r_e1[1]; w_my[5] = r_e2[0];
    end

    always_comb begin
        w_or  = r_mag[tsps_pkg::ST_MAG][0] | r_mag[tsps_pkg::ST_MAG][1]
              | r_mag[tsps_pkg::ST_MAG][2];
        w_len = '0;
        for (int k = 0; k < 66; k++) begin
            if (w_or[k]) begin
                w_len = 7'(k + 1);
            end
        end
    end

    // Control travels with the beat; pick up the signs and the degenerate flag
    // at the stages that produce them.
    always_comb begin
        n_nc[tsps_pkg::ST_EDGE] = '{want: i_want_normal, zero: 1'b0, neg: 3'b000};
        for (int k = tsps_pkg::ST_EDGE + 1; k <= tsps_pkg::ST_OUT; k++) begin
            n_nc[k] = r_nc[k-1];
        end
        for (int i = 0; i < 3; i++) begin
            n_nc[tsps_pkg::ST_MAG].neg[i] = r_cross[i][66];
        end
        n_nc[tsps_pkg::ST_LEN].zero = (w_len == 7'd0);
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_len > 7'(tsps_pkg::MANT_W)) begin
                w_m[i] = 30'(r_mag[tsps_pkg::ST_LEN][i] >> (r_len - 7'(tsps_pkg::MANT_W)));
            end else begin
                w_m[i] = 30'(r_mag[tsps_pkg::ST_LEN][i] << (7'(tsps_pkg::MANT_W) - r_len));
            end
        end
    end

    assign w_norm = r_nsq[tsps_pkg::ST_NSQ_END].root;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_e1[0] <= 33'(i_ax) - 33'(i_cx);
            r_e1[1] <= 33'(i_ay) - 33'(i_cy);
            r_e1[2] <= 33'(i_az) - 33'(i_cz);
            r_e2[0] <= 33'(i_bx) - 33'(i_cx);
            r_e2[1] <= 33'(i_by) - 33'(i_cy);
            r_e2[2] <= 33'(i_bz) - 33'(i_cz);
            r_nc <= n_nc;
            // split the second operand: low 17 bits unsigned, high 16 signed
            for (int p = 0; p < 6; p++) begin
                r_pl[p] <= 51'(w_mx[p]) * 51'($signed({1'b0, w_my[p][16:0]}));
                r_ph[p] <= 49'(w_mx[p]) * 49'($signed(w_my[p][32:17]));
                r_prod[p] <= (66'(r_ph[p]) <<< 17) + 66'(r_pl[p]);
            end
            for (int i = 0; i < 3; i++) begin
                r_cross[i] <= 67'(r_prod[2*i]) - 67'(r_prod[2*i+1]);
                r_mag[tsps_pkg::ST_MAG][i] <= r_cross[i][66] ? 66'(-r_cross[i])
                                                             : 66'(r_cross[i]);
                r_mag[tsps_pkg::ST_LEN][i] <= r_mag[tsps_pkg::ST_MAG][i];
                r_m[tsps_pkg::ST_MANT][i] <= w_m[i];
                r_sqr[i] <= 60'(r_m[tsps_pkg::ST_MANT][i]) * 60'(r_m[tsps_pkg::ST_MANT][i]);
            end
            r_len <= w_len;
            for (int k = tsps_pkg::ST_MANT + 1; k <= tsps_pkg::ST_NUM; k++) begin
                r_m[k] <= r_m[k-1];
            end
            r_nsq[tsps_pkg::ST_SUM] <= '{rad: 64'(r_sqr[0]) + 64'(r_sqr[1]) + 64'(r_sqr[2]),
                                         rem: '0, root: '0};
            for (int k = tsps_pkg::ST_SUM + 1; k <= tsps_pkg::ST_NSQ_END; k++) begin
                r_nsq[k] <= sq_step(sq_step(r_nsq[k-1]));
            end
            // numerator m*16384 + norm/2 for round half up
            r_dvd[tsps_pkg::ST_NUM] <= w_norm;
            for (int i = 0; i < 3; i++) begin
                r_dv[tsps_pkg::ST_NUM][i] <= '{
                    rem: (tsps_pkg::DIV_W'(r_m[tsps_pkg::ST_NUM-1][i]) << 14)
                         + tsps_pkg::DIV_W'(w_norm >> 1),
                    q: '0};
            end
            for (int k = tsps_pkg::ST_NUM + 1; k <= tsps_pkg::ST_DV_END; k++) begin
                r_dvd[k] <= r_dvd[k-1];
                for (int i = 0; i < 3; i++) begin
                    r_dv[k][i] <= div_step2(r_dv[k-1][i], r_dvd[k-1],
                                            15 - 2*(k - tsps_pkg::ST_NUM - 1));
                end
            end
            // restore sign; drop to zero when not requested or degenerate
            for (int i = 0; i < 3; i++) begin
                if (!r_nc[tsps_pkg::ST_DV_END].want || r_nc[tsps_pkg::ST_DV_END].zero) begin
                    r_nrm[i] <= '0;
                end else if (r_nc[tsps_pkg::ST_DV_END].neg[i]) begin
                    r_nrm[i] <= -$signed(r_dv[tsps_pkg::ST_DV_END][i].q);
                end else begin
                    r_nrm[i] <= $signed(r_dv[tsps_pkg::ST_DV_END][i].q);
                end
            end
        end
    end

    assign o_px = r_pt[tsps_pkg::ST_OUT][0];
    assign o_py = r_pt[tsps_pkg::ST_OUT][1];
    assign o_pz = r_pt[tsps_pkg::ST_OUT][2];
    assign o_nx = r_nrm[0];
    assign o_ny = r_nrm[1];
    assign o_nz = r_nrm[2];

    `TSPS_ASSERT_IMP(a_nrm_off, i_clk, i_rst_n, o_valid && !r_nc[tsps_pkg::ST_OUT].want, o_nx == '0 && o_ny == '0 && o_nz == '0)
    `TSPS_ASSERT_IMP(a_nrm_live, i_clk, i_rst_n, o_valid && r_nc[tsps_pkg::ST_OUT].want && !r_nc[tsps_pkg::ST_OUT].zero, o_nx != '0 || o_ny != '0 || o_nz != '0)
    `TSPS_ASSERT_IMP(a_nrm_rng, i_clk, i_rst_n, o_valid, o_nx <= tsps_pkg::Q14_ONE && o_nx >= -tsps_pkg::Q14_ONE && o_nz <= tsps_pkg::Q14_ONE && o_nz >= -tsps_pkg::Q14_ONE)
    `TSPS_ASSERT_NXT(a_hold, i_clk, i_rst_n, !w_adv, $stable(r_vld))
    `TSPS_ASSERT_NXT(a_take, i_clk, i_rst_n, i_valid && !o_stall, r_vld[tsps_pkg::ST_EDGE])

endmodule
